@@ rtl/qwt_pkg.sv @@
// ----------------------------------------------------------------------------
// qwt_pkg
// Shared types and constants for the quoted word tokenizer.
// ----------------------------------------------------------------------------
package qwt_pkg;

  localparam int MAX_WORDS_DEF      = 16;
  localparam int MAX_WORD_CHARS_DEF = 127;

  // Configuration register widths and indexes
  localparam int WLIM_W = 5;
  localparam int LLIM_W = 7;
  localparam int CFG_W  = 7;

  localparam logic CFG_WORD_LIMIT   = 1'b0;
  localparam logic CFG_LENGTH_LIMIT = 1'b1;

  localparam logic [WLIM_W-1:0] WORD_LIMIT_RST   = 5'd16;
  localparam logic [LLIM_W-1:0] LENGTH_LIMIT_RST = 7'd127;

  // Input kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Result field widths
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 4;
  localparam int TOTAL_W = 5;

  // Result queue depth (power of two, room for two beats per item)
  localparam int RQ_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_BARE = 2'd1,
    ESC_DQ   = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNCLOSED = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_TOO_MANY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RK_CHAR   = 2'd0,
    RK_END    = 2'd1,
    RK_STATUS = 2'd2
  } rkind_t;

  typedef struct packed {
    rkind_t              rkind;
    logic [CHAR_W-1:0]   ch;
    logic [IDX_W-1:0]    idx;
    logic [TOTAL_W-1:0]  total;
    status_t             status;
    logic                last;
  } result_t;

endpackage

@@ rtl/quoted_word_tokenizer.sv @@
// ----------------------------------------------------------------------------
// quoted_word_tokenizer
// Shell-style word splitter for one line fed a byte per beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): kind 0 carries a byte of the line in
// char_code, kind 1 marks end of line. Each input beat gives zero, one or two
// result beats on the output channel (out_valid/out_stall): word characters,
// word ends and, at end of line, a line status with the word total. The last
// result of an item has last set.
// Results are written into the result queue, which registers them, before they
// leave. Throughput: one input beat per cycle while each item gives at most one
// result and out_stall is low; an item giving two results sends them one at a
// time. The rate is set by the single output port of the four-entry result queue.
// in_stall rises while the queue cannot take a two-beat item, so an output
// stall backs up into the input; nothing is dropped.
// Reset clears the line state and the queue and loads word_limit with 16
// and word_length_limit with 127. Configuration writes (cfg_write, cfg_index,
// cfg_data) are registered and should be made while the block is idle.
// ----------------------------------------------------------------------------
module quoted_word_tokenizer #(
  parameter int MAX_WORDS      = qwt_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_CHARS = qwt_pkg::MAX_WORD_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [qwt_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [7:0]                  char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  result_kind,
  output logic [qwt_pkg::CHAR_W-1:0]  word_char,
  output logic [qwt_pkg::IDX_W-1:0]   word_index,
  output logic [qwt_pkg::TOTAL_W-1:0] word_total,
  output logic [1:0]                  status_code,
  output logic                        last
);

  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int LEN_W = $clog2(MAX_WORD_CHARS + 1);

  logic [qwt_pkg::WLIM_W-1:0] word_limit;
  logic [qwt_pkg::LLIM_W-1:0] word_length_limit;
  logic [CNT_W-1:0]           word_lim;
  logic [LEN_W-1:0]           len_lim;
  logic                       accept, room, push_a, push_b;
  qwt_pkg::result_t           res_a, res_b, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_limit        <= qwt_pkg::WORD_LIMIT_RST;
      word_length_limit <= qwt_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        qwt_pkg::CFG_WORD_LIMIT:   word_limit        <= qwt_pkg::WLIM_W'(cfg_data);
        qwt_pkg::CFG_LENGTH_LIMIT: word_length_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp limits to 1..maximum
  assign word_lim = (word_limit == '0) ? CNT_W'(1) :
                    (32'(word_limit) > 32'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) :
                    CNT_W'(word_limit);
  assign len_lim  = (word_length_limit == '0) ? LEN_W'(1) :
                    (32'(word_length_limit) > 32'(MAX_WORD_CHARS)) ? LEN_W'(MAX_WORD_CHARS) :
                    LEN_W'(word_length_limit);

  assign in_stall = !room;
  assign accept   = in_valid && room;

  qwt_parser #(
    .CNT_W (CNT_W),
    .LEN_W (LEN_W)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .char_code (char_code),
    .word_lim  (word_lim),
    .len_lim   (len_lim),
    .push_a    (push_a),
    .push_b    (push_b),
    .res_a     (res_a),
    .res_b     (res_b)
  );

  qwt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a && accept),
    .push_b    (push_b && accept),
    .data_a    (res_a),
    .data_b    (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign result_kind = head.rkind;
  assign word_char   = head.ch;
  assign word_index  = head.idx;
  assign word_total  = head.total;
  assign status_code = head.status;
  assign last        = head.last;

endmodule

@@ rtl/qwt_parser.sv @@
// ----------------------------------------------------------------------------
// qwt_parser
// Line state and per-byte decode; yields up to two result beats per item.
// ----------------------------------------------------------------------------
module qwt_parser #(
  parameter int CNT_W = 5,
  parameter int LEN_W = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 kind,
  input  logic [7:0]           char_code,
  input  logic [CNT_W-1:0]     word_lim,
  input  logic [LEN_W-1:0]     len_lim,
  output logic                 push_a,
  output logic                 push_b,
  output qwt_pkg::result_t     res_a,
  output qwt_pkg::result_t     res_b
);

  qwt_pkg::quote_t    quote, quote_next;
  qwt_pkg::esc_t      esc, esc_next;
  qwt_pkg::status_t   err, err_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [CNT_W-1:0]   cnt, cnt_next;

  function automatic logic append_ok(input logic [CNT_W-1:0] wl,
                                     input logic [LEN_W-1:0] ll,
                                     input logic [CNT_W-1:0] n,
                                     inout logic [LEN_W-1:0] l,
                                     inout qwt_pkg::status_t er);
    logic ok;
    ok = 1'b0;
    if (er == qwt_pkg::ST_OK) begin
      if (l == '0 && n >= wl) begin
        er = qwt_pkg::ST_TOO_MANY;
      end else if (l >= ll) begin
        er = qwt_pkg::ST_TOO_LONG;
      end else begin
        ok = 1'b1;
        l  = l + LEN_W'(1);
      end
    end
    return ok;
  endfunction

  function automatic qwt_pkg::result_t char_res(input logic [7:0] c,
                                                input logic [CNT_W-1:0] n);
    qwt_pkg::result_t r;
    r       = '0;
    r.rkind = qwt_pkg::RK_CHAR;
    r.ch    = c;
    r.idx   = qwt_pkg::IDX_W'(n);
    return r;
  endfunction

  function automatic qwt_pkg::result_t end_res(input logic [CNT_W-1:0] n);
    qwt_pkg::result_t r;
    r       = '0;
    r.rkind = qwt_pkg::RK_END;
    r.idx   = qwt_pkg::IDX_W'(n);
    return r;
  endfunction

  always_comb begin
    logic             run_plain;
    logic             pe;
    qwt_pkg::result_t pr;
    qwt_pkg::result_t sr;
    qwt_pkg::quote_t  qc;
    qwt_pkg::status_t st;
    run_plain  = 1'b0;
    pe         = 1'b0;
    pr         = '0;
    sr         = '0;
    qc         = qwt_pkg::Q_NONE;
    st         = err;
    quote_next = quote;
    esc_next   = esc;
    len_next   = len;
    cnt_next   = cnt;
    err_next   = err;
    push_a     = 1'b0;
    push_b     = 1'b0;
    res_a      = '0;
    res_b      = '0;

    if (kind == qwt_pkg::KIND_CHAR) begin
      if (err == qwt_pkg::ST_OK) begin
        case (esc)
          qwt_pkg::ESC_BARE: begin
            esc_next = qwt_pkg::ESC_NONE;
            push_a   = append_ok(word_lim, len_lim, cnt_next, len_next, err_next);
            res_a    = char_res(char_code, cnt_next);
          end
          qwt_pkg::ESC_DQ: begin
            esc_next = qwt_pkg::ESC_NONE;
            if (char_code == qwt_pkg::CH_DQUOTE || char_code == qwt_pkg::CH_BSLASH ||
                char_code == qwt_pkg::CH_DOLLAR || char_code == qwt_pkg::CH_NL) begin
              push_a = append_ok(word_lim, len_lim, cnt_next, len_next, err_next);
              res_a  = char_res(char_code, cnt_next);
            end else begin
              // backslash stays literal, then the byte is taken as usual
              push_a    = append_ok(word_lim, len_lim, cnt_next, len_next, err_next);
              res_a     = char_res(qwt_pkg::CH_BSLASH, cnt_next);
              run_plain = (err_next == qwt_pkg::ST_OK);
            end
          end
          default: run_plain = 1'b1;
        endcase

        if (run_plain) begin
          if (char_code == qwt_pkg::CH_SQUOTE || char_code == qwt_pkg::CH_DQUOTE) begin
            qc = (char_code == qwt_pkg::CH_SQUOTE) ? qwt_pkg::Q_SINGLE : qwt_pkg::Q_DOUBLE;
            if (quote_next == qwt_pkg::Q_NONE) begin
              quote_next = qc;
            end else if (quote_next == qc) begin
              quote_next = qwt_pkg::Q_NONE;
            end else begin
              pe = append_ok(word_lim, len_lim, cnt_next, len_next, err_next);
              pr = char_res(char_code, cnt_next);
            end
          end else if (char_code == qwt_pkg::CH_BSLASH && quote_next == qwt_pkg::Q_DOUBLE) begin
            esc_next = qwt_pkg::ESC_DQ;
          end else if (char_code == qwt_pkg::CH_BSLASH && quote_next == qwt_pkg::Q_NONE) begin
            esc_next = qwt_pkg::ESC_BARE;
          end else if (quote_next == qwt_pkg::Q_NONE &&
                       (char_code == qwt_pkg::CH_SPACE || char_code == qwt_pkg::CH_TAB)) begin
            if (len_next != '0) begin
              pe       = 1'b1;
              pr       = end_res(cnt_next);
              cnt_next = cnt_next + CNT_W'(1);
              len_next = '0;
            end
          end else begin
            pe = append_ok(word_lim, len_lim, cnt_next, len_next, err_next);
            pr = char_res(char_code, cnt_next);
          end
        end

        if (pe) begin
          if (push_a) begin
            push_b = 1'b1;
            res_b  = pr;
          end else begin
            push_a = 1'b1;
            res_a  = pr;
          end
        end
      end
    end else begin
      // end of line: flush the open word, report status, clear the line
      if (st == qwt_pkg::ST_OK) begin
        if (quote != qwt_pkg::Q_NONE) begin
          st = qwt_pkg::ST_UNCLOSED;
        end else if (len != '0) begin
          pe       = 1'b1;
          pr       = end_res(cnt);
          cnt_next = cnt + CNT_W'(1);
        end
      end
      sr        = '0;
      sr.rkind  = qwt_pkg::RK_STATUS;
      sr.total  = qwt_pkg::TOTAL_W'(cnt_next);
      sr.status = st;
      if (pe) begin
        push_a = 1'b1;
        res_a  = pr;
        push_b = 1'b1;
        res_b  = sr;
      end else begin
        push_a = 1'b1;
        res_a  = sr;
      end
      quote_next = qwt_pkg::Q_NONE;
      esc_next   = qwt_pkg::ESC_NONE;
      len_next   = '0;
      cnt_next   = '0;
      err_next   = qwt_pkg::ST_OK;
    end

    if (push_b) begin
      res_b.last = 1'b1;
    end else if (push_a) begin
      res_a.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote <= qwt_pkg::Q_NONE;
      esc   <= qwt_pkg::ESC_NONE;
      err   <= qwt_pkg::ST_OK;
      len   <= '0;
      cnt   <= '0;
    end else if (accept) begin
      quote <= quote_next;
      esc   <= esc_next;
      err   <= err_next;
      len   <= len_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/qwt_result_fifo.sv @@
// ----------------------------------------------------------------------------
// qwt_result_fifo
// Small result queue: takes up to two beats per cycle, hands out one unless out_stall is high.
// ----------------------------------------------------------------------------
module qwt_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_a,
  input  logic              push_b,
  input  qwt_pkg::result_t  data_a,
  input  qwt_pkg::result_t  data_b,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output qwt_pkg::result_t  head
);

  localparam int PTR_W = $clog2(qwt_pkg::RQ_DEPTH);
  localparam int CNT_W = $clog2(qwt_pkg::RQ_DEPTH + 1);

  qwt_pkg::result_t  mem [qwt_pkg::RQ_DEPTH];
  logic [PTR_W-1:0]  wr, rd, wr_b;
  logic [CNT_W-1:0]  count, n_push, n_pop;
  logic              pop;

  assign pop    = out_valid && !out_stall;
  assign wr_b   = wr + PTR_W'(1);
  assign n_push = CNT_W'(push_a) + CNT_W'(push_b);
  assign n_pop  = CNT_W'(pop);

  // leave space for a two-beat item
  assign room      = count <= CNT_W'(qwt_pkg::RQ_DEPTH - 2);
  assign out_valid = count != '0;
  assign head      = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + PTR_W'(n_push);
      rd    <= rd + PTR_W'(pop);
      count <= count + n_push - n_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr] <= data_a;
    end
    if (push_b) begin
      mem[wr_b] <= data_b;
    end
  end

endmodule

@@ tb/quoted_word_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_tb
// Self-checking bench for the shell-style word splitter.
// ----------------------------------------------------------------------------
// Lines go in one byte per beat, each closed by an end-of-line beat. A
// behavioural tokenizer in the bench works out the word characters, word ends
// and line status for every accepted beat. A monitor compares each output beat
// field by field with the oldest expected one. Directed lines cover quoting,
// escapes and the error cases. Random lines, mostly well formed, run under
// changing limits, with random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
module quoted_word_tokenizer_tb;
  import qwt_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 10;
  localparam int RANDOM_BEATS = 400;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = CFG_WORD_LIMIT;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              kind      = KIND_CHAR;
  logic [7:0]        char_code = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        result_kind;
  logic [CHAR_W-1:0] word_char;
  logic [IDX_W-1:0]  word_index;
  logic [TOTAL_W-1:0] word_total;
  logic [1:0]        status_code;
  logic              last;

  quoted_word_tokenizer DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .char_code(char_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .word_char(word_char), .word_index(word_index),
    .word_total(word_total), .status_code(status_code), .last(last)
  );

  always #10 clk = ~clk;

  // Tokenizer state and register copies
  quote_t            tok_quote = Q_NONE;
  esc_t              tok_esc   = ESC_NONE;
  status_t           tok_err   = ST_OK;
  int                tok_len   = 0;
  int                tok_cnt   = 0;
  logic [WLIM_W-1:0] lim_words = WORD_LIMIT_RST;
  logic [LLIM_W-1:0] lim_chars = LENGTH_LIMIT_RST;

  result_t    beat_tokens[$];
  result_t    expected_tokens[$];
  logic [7:0] line_bytes[$];

  int mismatches   = 0;
  int cycles       = 0;
  int stall_left   = 0;
  int stall_mode   = 0;
  bit send_idling  = 1'b0;

  // ---------------------------------------------------------------- tokenizer
  function automatic int word_cap();
    if (lim_words == 0) return 1;
    if (lim_words > MAX_WORDS_DEF) return MAX_WORDS_DEF;
    return lim_words;
  endfunction

  function automatic int length_cap();
    if (lim_chars == 0) return 1;
    if (lim_chars > MAX_WORD_CHARS_DEF) return MAX_WORD_CHARS_DEF;
    return lim_chars;
  endfunction

  function automatic void add_token(rkind_t rk, logic [7:0] ch, int idx, int total,
                                    status_t st);
    result_t r;
    r.rkind  = rk;
    r.ch     = ch;
    r.idx    = IDX_W'(idx);
    r.total  = TOTAL_W'(total);
    r.status = st;
    r.last   = 1'b0;
    beat_tokens.push_back(r);
  endfunction

  function automatic void append_char(logic [7:0] c);
    if (tok_err != ST_OK) return;
    if (tok_len == 0 && tok_cnt >= word_cap()) begin
      tok_err = ST_TOO_MANY;
      return;
    end
    if (tok_len >= length_cap()) begin
      tok_err = ST_TOO_LONG;
      return;
    end
    add_token(RK_CHAR, c, tok_cnt, 0, ST_OK);
    tok_len++;
  endfunction

  function automatic void plain_char(logic [7:0] c);
    quote_t q;
    if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      q = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
      if (tok_quote == Q_NONE) tok_quote = q;
      else if (tok_quote == q) tok_quote = Q_NONE;
      else append_char(c);
      return;
    end
    if (c == CH_BSLASH && tok_quote == Q_DOUBLE) begin
      tok_esc = ESC_DQ;
      return;
    end
    if (c == CH_BSLASH && tok_quote == Q_NONE) begin
      tok_esc = ESC_BARE;
      return;
    end
    if (tok_quote == Q_NONE && (c == CH_SPACE || c == CH_TAB)) begin
      if (tok_len == 0) return;
      add_token(RK_END, 8'h00, tok_cnt, 0, ST_OK);
      tok_cnt++;
      tok_len = 0;
      return;
    end
    append_char(c);
  endfunction

  function automatic void tokenize_beat(logic k, logic [7:0] c);
    status_t st;
    beat_tokens.delete();
    if (k == KIND_CHAR) begin
      if (tok_err != ST_OK) return;
      if (tok_esc == ESC_BARE) begin
        tok_esc = ESC_NONE;
        append_char(c);
      end else if (tok_esc == ESC_DQ) begin
        tok_esc = ESC_NONE;
        if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_NL) begin
          append_char(c);
        end else begin
          // backslash stays literal before an ordinary byte
          append_char(CH_BSLASH);
          if (tok_err == ST_OK) plain_char(c);
        end
      end else begin
        plain_char(c);
      end
    end else begin
      st = tok_err;
      if (st == ST_OK) begin
        if (tok_quote != Q_NONE) begin
          st = ST_UNCLOSED;
        end else if (tok_len > 0) begin
          add_token(RK_END, 8'h00, tok_cnt, 0, ST_OK);
          tok_cnt++;
        end
      end
      add_token(RK_STATUS, 8'h00, 0, tok_cnt, st);
      tok_quote = Q_NONE;
      tok_esc   = ESC_NONE;
      tok_len   = 0;
      tok_cnt   = 0;
      tok_err   = ST_OK;
    end
    if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size()-1].last = 1'b1;
    foreach (beat_tokens[i]) expected_tokens.push_back(beat_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- idling
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (stall_mode != 0 && $urandom_range(0, 4 - stall_mode) == 0)
      stall_left = random_gap();
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("[%0d] MISMATCH %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t exp_tok;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d char=%02h",
                                  result_kind, word_char));
      end else begin
        exp_tok = expected_tokens.pop_front();
        if (result_kind !== exp_tok.rkind || word_char !== exp_tok.ch ||
            word_index !== exp_tok.idx || word_total !== exp_tok.total ||
            status_code !== exp_tok.status || last !== exp_tok.last)
          report_mismatch($sformatf(
            "got k%0d c%02h i%0d t%0d s%0d l%0d exp k%0d c%02h i%0d t%0d s%0d l%0d",
            result_kind, word_char, word_index, word_total, status_code, last,
            exp_tok.rkind, exp_tok.ch, exp_tok.idx, exp_tok.total,
            exp_tok.status, exp_tok.last));
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_beat(input logic k, input logic [7:0] c);
    int gap;
    gap = 0;
    if (send_idling && $urandom_range(0, 2) == 0) gap = random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= c;
    do @(posedge clk); while (!(in_valid && !in_stall));
    tokenize_beat(k, c);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_beat(KIND_CHAR, line_bytes[i]);
    send_beat(KIND_EOL, 8'($urandom));
    line_bytes.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limits(input int words, input int chars);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_WORD_LIMIT;
    cfg_data  <= {2'($urandom), WLIM_W'(words)};
    @(posedge clk);
    cfg_index <= CFG_LENGTH_LIMIT;
    cfg_data  <= LLIM_W'(chars);
    @(posedge clk);
    cfg_write <= 1'b0;
    lim_words = WLIM_W'(words);
    lim_chars = LLIM_W'(chars);
  endtask

  // ---------------------------------------------------------------- line build
  function automatic bit is_special(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE ||
           c == CH_BSLASH;
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    if ($urandom_range(0, 2) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    do c = 8'($urandom); while (is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom); while (c == a || c == b);
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 58) return CH_SPACE;
    if (r < 62) return CH_TAB;
    if (r < 70) return CH_SQUOTE;
    if (r < 78) return CH_DQUOTE;
    if (r < 86) return CH_BSLASH;
    if (r < 89) return CH_DOLLAR;
    if (r < 91) return CH_NL;
    return 8'($urandom);
  endfunction

  function automatic void build_line();
    int nwords;
    if ($urandom_range(0, 4) == 0) begin
      // noise, often with unbalanced quotes
      repeat ($urandom_range(0, 30)) line_bytes.push_back(noise_byte());
      return;
    end
    nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 18) : $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) line_bytes.push_back(CH_TAB);
    for (int w = 0; w < nwords; w++) begin
      if (w > 0)
        repeat ($urandom_range(1, 2))
          line_bytes.push_back($urandom_range(0, 2) ? CH_SPACE : CH_TAB);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 5)) line_bytes.push_back(word_byte());
          1: begin
            line_bytes.push_back(CH_SQUOTE);
            repeat ($urandom_range(0, 4))
              line_bytes.push_back(byte_except(CH_SQUOTE, CH_SQUOTE));
            line_bytes.push_back(CH_SQUOTE);
          end
          2: begin
            line_bytes.push_back(CH_DQUOTE);
            repeat ($urandom_range(0, 4)) begin
              if ($urandom_range(0, 2) == 0) begin
                line_bytes.push_back(CH_BSLASH);
                case ($urandom_range(0, 4))
                  0: line_bytes.push_back(CH_DQUOTE);
                  1: line_bytes.push_back(CH_BSLASH);
                  2: line_bytes.push_back(CH_DOLLAR);
                  3: line_bytes.push_back(CH_NL);
                  default: line_bytes.push_back(byte_except(CH_DQUOTE, CH_BSLASH));
                endcase
              end else begin
                line_bytes.push_back(byte_except(CH_DQUOTE, CH_BSLASH));
              end
            end
            line_bytes.push_back(CH_DQUOTE);
          end
          default: begin
            line_bytes.push_back(CH_BSLASH);
            line_bytes.push_back(8'($urandom));
          end
        endcase
      end
    end
    if ($urandom_range(0, 3) == 0) line_bytes.push_back(CH_SPACE);
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // escaped blank, empty quotes, escapes and a stray quote inside double quotes
    queue_text("x\\ '' \"\\\"\\$\\q'\"");
    send_line();
    // byte zero, top byte, tab separator, trailing bare backslash
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(CH_TAB);
    line_bytes.push_back(CH_BSLASH);
    send_line();
    // backslash inside double quotes left hanging at end of line
    queue_text("\"a\\");
    send_line();
    queue_text("'");
    send_line();
    send_line();
  endtask

  task automatic test_limits();
    stall_mode  = 1;
    send_idling = 1'b1;
    // longest word allowed at reset limits, then one byte over
    repeat (MAX_WORD_CHARS_DEF) line_bytes.push_back(8'h6B);
    send_line();
    repeat (MAX_WORD_CHARS_DEF + 1) line_bytes.push_back(8'h6B);
    send_line();
    // sixteen words, then seventeen
    repeat (MAX_WORDS_DEF) queue_text("w ");
    send_line();
    repeat (MAX_WORDS_DEF + 1) queue_text("w ");
    send_line();
    set_limits(1, 1);
    queue_text("a b");
    send_line();
    queue_text("ab");
    send_line();
    queue_text("'a'\\b");
    send_line();
    set_limits(0, 0);
    queue_text("a b");
    send_line();
    queue_text("\"\\q\"");
    send_line();
    set_limits(31, 2);
    queue_text("ab cd efg");
    send_line();
    set_limits(16, 127);
  endtask

  task automatic test_pause_for_results();
    stall_mode  = 2;
    send_idling = 1'b0;
    repeat (6) begin
      if (expected_tokens.size() != 0) begin
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
      end
      build_line();
      send_line();
    end
  endtask

  task automatic test_random_lines();
    int live;
    int line_no;
    live    = 0;
    line_no = 0;
    while (live < RANDOM_BEATS) begin
      if (line_no % 8 == 0) begin
        case ($urandom_range(0, 5))
          0: set_limits(16, 127);
          1: set_limits(1, 1);
          2: set_limits(0, 0);
          3: set_limits(31, $urandom_range(1, 127));
          default: set_limits($urandom_range(2, 8), $urandom_range(2, 10));
        endcase
      end
      stall_mode  = $urandom_range(0, 2);
      send_idling = $urandom_range(0, 2) != 0;
      build_line();
      foreach (line_bytes[i]) begin
        live++;
        send_beat(KIND_CHAR, line_bytes[i]);
      end
      line_bytes.delete();
      send_beat(KIND_EOL, 8'($urandom));
      live++;
      line_no++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_pause_for_results();
    test_random_lines();
    stall_mode = 0;
    wait_idle();
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
